// ===== hw/rtl/trace_body_boundary_picker_defines.svh =====
// assertion macros for the trace body boundary picker
`ifndef TRACE_BODY_BOUNDARY_PICKER_DEFINES_SVH
`define TRACE_BODY_BOUNDARY_PICKER_DEFINES_SVH

// same-cycle implication, off while in reset
`define TBBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbbp assertion failed");

// next-cycle implication, off while in reset
`define TBBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbbp assertion failed");

`endif

// ===== hw/rtl/tbbp_pkg.sv =====
// shared types and constants for the trace body boundary picker
package tbbp_pkg;

    localparam int DEFAULT_MAX_TRACE_SAMPLES = 4096;
    localparam int VAL_W = 32;
    localparam int TOL_W = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [VAL_W-1:0] TARGET_RESET = '0;
    localparam logic [TOL_W-1:0] TOLERANCE_RESET = 31'd655;
    localparam logic signed [VAL_W-1:0] NULL_RESET = '0;
    localparam logic signed [VAL_W-1:0] ORIGIN_RESET = '0;
    localparam logic signed [VAL_W-1:0] STEP_RESET = 32'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET    = 3'd0,
        CFG_TOLERANCE = 3'd1,
        CFG_NULL      = 3'd2,
        CFG_ORIGIN    = 3'd3,
        CFG_STEP      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample;
        logic                    last_in_trace;
    } smp_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] top_depth;
        logic signed [VAL_W-1:0] overhang_top_depth;
        logic signed [VAL_W-1:0] overhang_bottom_depth;
        logic signed [VAL_W-1:0] bottom_depth;
    } pick_t;

    typedef struct packed {
        logic mul_en;
        logic out_en;
    } depth_ctrl_t;

endpackage

// ===== hw/rtl/tbbp_depth.sv =====
// index to depth conversion: multiply stage, then offset, saturate or null depth stage
module tbbp_depth #(
    parameter int IDX_W = 12
) (
    input  logic                               clk,
    input  tbbp_pkg::depth_ctrl_t              ctrl,
    input  logic                               found,
    input  logic [IDX_W-1:0]                   index,
    input  logic signed [tbbp_pkg::VAL_W-1:0]  origin,
    input  logic signed [tbbp_pkg::VAL_W-1:0]  step,
    input  logic signed [tbbp_pkg::VAL_W-1:0]  null_depth,
    output logic signed [tbbp_pkg::VAL_W-1:0]  depth
);
    import tbbp_pkg::*;

    localparam int PROD_W = IDX_W + VAL_W + 1;
    localparam int SUM_W = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] DEPTH_MAX = SUM_W'($signed(32'h7FFF_FFFF));
    localparam logic signed [SUM_W-1:0] DEPTH_MIN = SUM_W'($signed(32'h8000_0000));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     found_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [VAL_W-1:0]  depth_reg;
    logic signed [VAL_W-1:0]  depth_next;

    assign prod_next = PROD_W'($signed({1'b0, index})) * PROD_W'(step);
    assign sum = SUM_W'(prod_reg) + SUM_W'(origin);

    always_comb
    begin
        if (!found_reg)
        begin
            depth_next = null_depth;
        end
        else if (sum > DEPTH_MAX)
        begin
            depth_next = DEPTH_MAX[VAL_W-1:0];
        end
        else if (sum < DEPTH_MIN)
        begin
            depth_next = DEPTH_MIN[VAL_W-1:0];
        end
        else
        begin
            depth_next = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg  <= prod_next;
            found_reg <= found;
        end
        if (ctrl.out_en)
        begin
            depth_reg <= depth_next;
        end
    end

    assign depth = depth_reg;

endmodule

// ===== hw/rtl/trace_body_boundary_picker.sv =====
// top level of the trace body boundary picker
//
//  channel | dir | handshake              | payload
//  smp     | in  | smp_valid / smp_ready  | smp_t: sample, last_in_trace
//  pick    | out | pick_valid / pick_ready| pick_t: four boundary depths
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one sample per cycle while no last sample waits; a sample is classified before
// the input register and folded into the trace state as it leaves that register
// a last sample reaches pick through the input register, the multiply register
// and then the output register
// rst_n clears all control and trace state but fidx_reg; no clearing pass
// a stalled pick holds its result; samples keep flowing, only a last
// sample waits in the input register while multiply and output stages are full
module trace_body_boundary_picker #(
    parameter int MAX_TRACE_SAMPLES = tbbp_pkg::DEFAULT_MAX_TRACE_SAMPLES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            smp_valid,
    output logic                            smp_ready,
    input  tbbp_pkg::smp_t                  smp,
    output logic                            pick_valid,
    input  logic                            pick_ready,
    output tbbp_pkg::pick_t                 pick,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tbbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbbp_pkg::VAL_W-1:0]      cfg_data
);
    import tbbp_pkg::*;

    localparam int IDX_W = $clog2(MAX_TRACE_SAMPLES);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_TRACE_SAMPLES - 1);

    typedef enum logic [2:0] {
        SEEK_TOP,
        SEEK_OH_TOP,
        SEEK_OH_BOT,
        SEEK_BOT,
        DONE
    } phase_t;

    // configuration
    logic signed [VAL_W-1:0] target_reg;
    logic [TOL_W-1:0]        tolerance_reg;
    logic signed [VAL_W-1:0] null_reg;
    logic signed [VAL_W-1:0] origin_reg;
    logic signed [VAL_W-1:0] step_reg;

    // classification ahead of the input register
    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]        mag;
    logic                  cur_in;
    logic                  cur_out;

    // input register
    logic s_valid_reg;
    logic s_valid_next;
    logic s_in_reg;
    logic s_out_reg;
    logic s_last_reg;

    // trace state
    phase_t           phase_reg;
    phase_t           phase_next;
    logic             prev_in_reg;
    logic             prev_in_next;
    logic             prev_out_reg;
    logic             prev_out_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] fidx_reg [4];
    logic [IDX_W-1:0] fidx_next [4];
    logic [3:0]       flags_reg;
    logic [3:0]       flags_next;
    logic [IDX_W-1:0] upd_idx [4];
    logic [3:0]       upd_flags;
    logic [IDX_W-1:0] fin_idx [4];
    logic [3:0]       fin_flags;

    // pipeline control
    logic        mul_valid_reg;
    logic        mul_valid_next;
    logic        pick_valid_reg;
    logic        pick_valid_next;
    logic        out_free;
    logic        mul_free;
    logic        s_go;
    logic        mul_load;
    logic        out_load;
    depth_ctrl_t dctrl;
    logic signed [VAL_W-1:0] depth [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            tolerance_reg <= TOLERANCE_RESET;
            null_reg      <= NULL_RESET;
            origin_reg    <= ORIGIN_RESET;
            step_reg      <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TARGET:    target_reg    <= $signed(cfg_data);
                CFG_TOLERANCE: tolerance_reg <= cfg_data[TOL_W-1:0];
                CFG_NULL:      null_reg      <= $signed(cfg_data);
                CFG_ORIGIN:    origin_reg    <= $signed(cfg_data);
                CFG_STEP:      step_reg      <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // |sample - target| against tolerance, exact in 33 bits
    assign diff = (VAL_W + 1)'(smp.sample) - (VAL_W + 1)'(target_reg);
    assign mag = diff[VAL_W] ? (VAL_W + 1)'(-diff) : (VAL_W + 1)'(diff);
    assign cur_in = mag < (VAL_W + 1)'(tolerance_reg);
    assign cur_out = mag > (VAL_W + 1)'(tolerance_reg);

    assign out_free = !pick_valid_reg || pick_ready;
    assign mul_free = !mul_valid_reg || out_free;
    assign s_go = s_valid_reg && (!s_last_reg || mul_free);
    assign smp_ready = !s_valid_reg || s_go;
    assign mul_load = s_go && s_last_reg;
    assign out_load = mul_valid_reg && out_free;

    assign s_valid_next = (smp_valid && smp_ready) || (s_valid_reg && !s_go);
    assign mul_valid_next = mul_load || (mul_valid_reg && !out_free);
    assign pick_valid_next = out_load || (pick_valid_reg && !pick_ready);

    // boundary search for the sample in the input register
    always_comb
    begin
        phase_next = phase_reg;
        upd_idx    = fidx_reg;
        upd_flags  = flags_reg;
        unique case (phase_reg)
            SEEK_TOP:
            begin
                if (s_in_reg)
                begin
                    upd_idx[0]   = pos_reg;
                    upd_flags[0] = 1'b1;
                    phase_next   = SEEK_OH_TOP;
                end
            end
            SEEK_OH_TOP:
            begin
                if (prev_in_reg && s_out_reg)
                begin
                    upd_idx[1]   = pos_reg - IDX_W'(1);
                    upd_flags[1] = 1'b1;
                    phase_next   = SEEK_OH_BOT;
                end
            end
            SEEK_OH_BOT:
            begin
                if (prev_out_reg && s_in_reg)
                begin
                    upd_idx[2]   = pos_reg;
                    upd_flags[2] = 1'b1;
                    phase_next   = SEEK_BOT;
                end
            end
            SEEK_BOT:
            begin
                if (prev_in_reg && s_out_reg)
                begin
                    upd_idx[3]   = pos_reg - IDX_W'(1);
                    upd_flags[3] = 1'b1;
                    phase_next   = DONE;
                end
            end
            default: ;
        endcase

        // end of trace: inside last sample closes the body,
        // lone overhang top turns into the bottom
        fin_idx   = upd_idx;
        fin_flags = upd_flags;
        if (s_in_reg)
        begin
            fin_idx[3]   = pos_reg;
            fin_flags[3] = 1'b1;
        end
        if (fin_flags == 4'b0011)
        begin
            fin_idx[3] = fin_idx[1];
            fin_flags  = 4'b1001;
        end

        fidx_next     = fidx_reg;
        flags_next    = flags_reg;
        prev_in_next  = prev_in_reg;
        prev_out_next = prev_out_reg;
        pos_next      = pos_reg;
        if (s_go)
        begin
            fidx_next = upd_idx;
            if (s_last_reg)
            begin
                phase_next    = SEEK_TOP;
                flags_next    = '0;
                prev_in_next  = 1'b0;
                prev_out_next = 1'b0;
                pos_next      = '0;
            end
            else
            begin
                flags_next    = upd_flags;
                prev_in_next  = s_in_reg;
                prev_out_next = s_out_reg;
                if (pos_reg != LAST_POS)
                begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
        end
        else
        begin
            phase_next = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg    <= 1'b0;
            mul_valid_reg  <= 1'b0;
            pick_valid_reg <= 1'b0;
            phase_reg      <= SEEK_TOP;
            prev_in_reg    <= 1'b0;
            prev_out_reg   <= 1'b0;
            pos_reg        <= '0;
            flags_reg      <= '0;
        end
        else
        begin
            s_valid_reg    <= s_valid_next;
            mul_valid_reg  <= mul_valid_next;
            pick_valid_reg <= pick_valid_next;
            phase_reg      <= phase_next;
            prev_in_reg    <= prev_in_next;
            prev_out_reg   <= prev_out_next;
            pos_reg        <= pos_next;
            flags_reg      <= flags_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (smp_valid && smp_ready)
        begin
            s_in_reg   <= cur_in;
            s_out_reg  <= cur_out;
            s_last_reg <= smp.last_in_trace;
        end
        fidx_reg <= fidx_next;
    end

    assign dctrl.mul_en = mul_load;
    assign dctrl.out_en = out_load;

    for (genvar k = 0; k < 4; k++)
    begin : g_depth
        tbbp_depth #(
            .IDX_W (IDX_W)
        ) u_depth (
            .clk        (clk),
            .ctrl       (dctrl),
            .found      (fin_flags[k]),
            .index      (fin_idx[k]),
            .origin     (origin_reg),
            .step       (step_reg),
            .null_depth (null_reg),
            .depth      (depth[k])
        );
    end

    assign pick_valid = pick_valid_reg;
    assign pick.top_depth = depth[0];
    assign pick.overhang_top_depth = depth[1];
    assign pick.overhang_bottom_depth = depth[2];
    assign pick.bottom_depth = depth[3];

endmodule

// ===== hw/rtl/tbbp_checker.sv =====
// port-level checks for the trace body boundary picker, bound to the top level
`include "trace_body_boundary_picker_defines.svh"

module tbbp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            smp_ready,
    input logic            pick_valid,
    input logic            pick_ready,
    input logic            cfg_ready,
    input tbbp_pkg::pick_t pick
);
    // a stalled result holds
    `TBBP_ASSERT_NEXT(a_pick_hold, clk, rst_n, pick_valid && !pick_ready, pick_valid && $stable(pick))
    // with no result pending the sample side never stalls
    `TBBP_ASSERT_IMPL(a_idle_takes_sample, clk, rst_n, !pick_valid, smp_ready)
    // register writes are never refused
    `TBBP_ASSERT_IMPL(a_cfg_always_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind trace_body_boundary_picker tbbp_checker u_tbbp_checker (.*);

// ===== tb/sv/tb_top.sv =====
// testbench for the trace body boundary picker: directed and random traces checked by a predictor
module tb_top;
    import tbbp_pkg::*;

    localparam int MAX_SAMPLES = DEFAULT_MAX_TRACE_SAMPLES;
    localparam int PIPE_DEPTH = 3;
    localparam int HANG_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int CFG_UNMAPPED_FIRST = int'(CFG_STEP) + 1;
    localparam longint DEPTH_MAX = 64'sd2147483647;
    localparam longint DEPTH_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        SEEK_TOP,
        SEEK_OH_TOP,
        SEEK_OH_BOTTOM,
        SEEK_BOTTOM,
        SEEK_DONE
    } seek_t;

    typedef enum logic [1:0] {
        ZONE_IN,
        ZONE_OUT,
        ZONE_EDGE,
        ZONE_ANY
    } zone_t;

    logic clk = 1'b0;
    logic rst_n;
    logic smp_valid;
    logic smp_ready;
    smp_t smp;
    logic pick_valid;
    logic pick_ready;
    pick_t pick;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0] cfg_data;

    longint cfg_target;
    longint cfg_tol;
    longint cfg_null;
    longint cfg_origin;
    longint cfg_step;

    seek_t seek;
    bit was_inside;
    bit was_outside;
    int position;
    int bound_idx[4];
    bit [3:0] bound_found;

    pick_t pending_picks[$];
    int mismatches = 0;
    int pick_hold = 0;
    int quiet_cycles = 0;
    bit steady = 1'b0;

    trace_body_boundary_picker uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp_valid  (smp_valid),
        .smp_ready  (smp_ready),
        .smp        (smp),
        .pick_valid (pick_valid),
        .pick_ready (pick_ready),
        .pick       (pick),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_bounds();
        seek = SEEK_TOP;
        was_inside = 1'b0;
        was_outside = 1'b0;
        position = 0;
        for (int k = 0; k < 4; k++)
        begin
            bound_idx[k] = 0;
        end
        bound_found = '0;
    endfunction

    function automatic void mark_bound(int k, int here);
        bound_idx[k] = here;
        bound_found[k] = 1'b1;
    endfunction

    function automatic logic signed [VAL_W-1:0] depth_at(int k);
        longint d;
        if (!bound_found[k])
        begin
            return cfg_null[VAL_W-1:0];
        end
        d = cfg_origin + longint'(bound_idx[k]) * cfg_step;
        if (d > DEPTH_MAX)
        begin
            d = DEPTH_MAX;
        end
        if (d < DEPTH_MIN)
        begin
            d = DEPTH_MIN;
        end
        return d[VAL_W-1:0];
    endfunction

    function automatic void fold_sample(smp_t s);
        longint distance;
        bit now_in;
        bit now_out;
        int here;
        pick_t r;
        distance = longint'($signed(s.sample)) - cfg_target;
        if (distance < 0)
        begin
            distance = -distance;
        end
        now_in = distance < cfg_tol;
        now_out = distance > cfg_tol;
        here = position;
        case (seek)
            SEEK_TOP:
            begin
                if (now_in)
                begin
                    mark_bound(0, here);
                    seek = SEEK_OH_TOP;
                end
            end
            SEEK_OH_TOP:
            begin
                if (was_inside && now_out)
                begin
                    mark_bound(1, here - 1);
                    seek = SEEK_OH_BOTTOM;
                end
            end
            SEEK_OH_BOTTOM:
            begin
                if (was_outside && now_in)
                begin
                    mark_bound(2, here);
                    seek = SEEK_BOTTOM;
                end
            end
            SEEK_BOTTOM:
            begin
                if (was_inside && now_out)
                begin
                    mark_bound(3, here - 1);
                    seek = SEEK_DONE;
                end
            end
            default:
            begin
            end
        endcase
        if (!s.last_in_trace)
        begin
            was_inside = now_in;
            was_outside = now_out;
            if (position < MAX_SAMPLES - 1)
            begin
                position++;
            end
        end
        else
        begin
            if (now_in)
            begin
                mark_bound(3, here);
            end
            // lone overhang top turns into the bottom
            if (bound_found == 4'b0011)
            begin
                bound_idx[3] = bound_idx[1];
                bound_found = 4'b1001;
            end
            r.top_depth = depth_at(0);
            r.overhang_top_depth = depth_at(1);
            r.overhang_bottom_depth = depth_at(2);
            r.bottom_depth = depth_at(3);
            pending_picks.push_back(r);
            clear_bounds();
        end
    endfunction

    function automatic logic [VAL_W-1:0] zone_value(zone_t z);
        longint off;
        logic [VAL_W-1:0] v;
        case (z)
            ZONE_IN: off = (cfg_tol == 0) ? 0 : longint'($urandom_range(0, 32'(cfg_tol - 1)));
            ZONE_OUT: off = cfg_tol + 1 + longint'($urandom_range(0, 4095));
            ZONE_EDGE: off = cfg_tol;
            default: return $urandom;
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            off = -off;
        end
        off = cfg_target + off;
        v = off[VAL_W-1:0];
        return v;
    endfunction

    task automatic check_depth(string field, logic signed [VAL_W-1:0] want,
                               logic signed [VAL_W-1:0] got);
        if (want !== got)
        begin
            if (mismatches < REPORT_LIMIT)
            begin
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
            end
            mismatches++;
        end
    endtask

    // result checker and pick side stall
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && pick_valid && pick_ready)
        begin
            if (pending_picks.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $display("unexpected result: top %0d", pick.top_depth);
                end
                mismatches++;
            end
            else
            begin
                want = pending_picks.pop_front();
                check_depth("top_depth", want.top_depth, pick.top_depth);
                check_depth("overhang_top_depth", want.overhang_top_depth,
                            pick.overhang_top_depth);
                check_depth("overhang_bottom_depth", want.overhang_bottom_depth,
                            pick.overhang_bottom_depth);
                check_depth("bottom_depth", want.bottom_depth, pick.bottom_depth);
            end
            pick_hold = steady ? 0 : $urandom_range(0, 10);
        end
        else if (pick_valid && pick_hold > 0)
        begin
            pick_hold--;
        end
    end

    always @(negedge clk)
    begin
        pick_ready <= (pick_hold == 0);
    end

    always @(posedge clk)
    begin
        if ((smp_valid && smp_ready) || (pick_valid && pick_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (cfg_reg_t'(idx))
            CFG_TARGET: cfg_target = longint'($signed(data));
            CFG_TOLERANCE: cfg_tol = longint'(data[TOL_W-1:0]);
            CFG_NULL: cfg_null = longint'($signed(data));
            CFG_ORIGIN: cfg_origin = longint'($signed(data));
            CFG_STEP: cfg_step = longint'($signed(data));
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [VAL_W-1:0] value, input logic last);
        int gap;
        smp_t item;
        gap = steady ? 0 : $urandom_range(0, 10);
        item.sample = value;
        item.last_in_trace = last;
        if (gap > 0)
        begin
            smp_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp_valid <= 1'b1;
        smp <= item;
        do
        begin
            @(posedge clk);
        end
        while (!smp_ready);
        fold_sample(item);
        @(negedge clk);
    endtask

    task automatic send_trace(input logic [VAL_W-1:0] vals[$]);
        for (int k = 0; k < vals.size(); k++)
        begin
            send_sample(vals[k], k == vals.size() - 1);
        end
    endtask

    task automatic wait_drained();
        smp_valid <= 1'b0;
        while (pending_picks.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic test_directed_shapes();
        logic [VAL_W-1:0] shape[$];
        // all four boundaries
        shape = {32'd5000, 32'd0, 32'd100, 32'd9000, 32'h8000_0000, 32'hFFFF_FFF0, 32'h7FFF_FFFF};
        send_trace(shape);
        // single inside sample
        shape = {32'd654};
        send_trace(shape);
        // distance equal to tolerance
        shape = {32'd655};
        send_trace(shape);
        // lone overhang top
        shape = {32'hFFFF_FD72, 32'd656};
        send_trace(shape);
        // inside to the end
        shape = {32'd0, 32'd0, 32'd0};
        send_trace(shape);
        shape = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FD71};
        send_trace(shape);
        // inside then neither then outside
        shape = {32'd1, 32'd655, 32'd700};
        send_trace(shape);
    endtask

    task automatic test_register_extremes();
        logic [VAL_W-1:0] shape[$];
        wait_drained();
        write_reg(CFG_TARGET, 32'h8000_0000);
        write_reg(CFG_TOLERANCE, 32'h7FFF_FFFF);
        write_reg(CFG_NULL, 32'h7FFF_FFFF);
        write_reg(CFG_ORIGIN, 32'h7FFF_FFFF);
        write_reg(CFG_STEP, 32'h7FFF_FFFF);
        shape = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE, 32'h7FFF_FFFF};
        send_trace(shape);
        wait_drained();
        write_reg(CFG_TARGET, 32'h7FFF_FFFF);
        write_reg(CFG_TOLERANCE, 32'd1);
        write_reg(CFG_NULL, 32'h8000_0000);
        write_reg(CFG_ORIGIN, 32'h8000_0000);
        write_reg(CFG_STEP, 32'h8000_0000);
        shape = {32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_trace(shape);
        wait_drained();
        write_reg(CFG_TOLERANCE, '0);
        write_reg(CFG_STEP, 32'd1);
        shape = {32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFE};
        send_trace(shape);
    endtask

    task automatic test_unmapped_index();
        logic [VAL_W-1:0] shape[$];
        wait_drained();
        write_reg(CFG_TARGET, 32'd4096);
        write_reg(CFG_TOLERANCE, 32'd300);
        write_reg(CFG_ORIGIN, 32'd1000);
        write_reg(CFG_STEP, 32'd7);
        for (int i = CFG_UNMAPPED_FIRST; i < (1 << CFG_IDX_W); i++)
        begin
            write_reg(i[CFG_IDX_W-1:0], $urandom);
        end
        shape = {zone_value(ZONE_OUT), zone_value(ZONE_IN), zone_value(ZONE_OUT),
                 zone_value(ZONE_IN)};
        send_trace(shape);
    endtask

    task automatic test_overlong_trace();
        zone_t z;
        wait_drained();
        write_reg(CFG_TARGET, '0);
        write_reg(CFG_TOLERANCE, 32'd655);
        write_reg(CFG_ORIGIN, '0);
        write_reg(CFG_STEP, 32'd1);
        steady = 1'b1;
        for (int k = 0; k <= MAX_SAMPLES + 4; k++)
        begin
            if (k < MAX_SAMPLES - 6)
            begin
                z = ZONE_OUT;
            end
            else if (k <= MAX_SAMPLES)
            begin
                z = ZONE_IN;
            end
            else
            begin
                z = ((k - MAX_SAMPLES) % 2 == 1) ? ZONE_OUT : ZONE_IN;
            end
            send_sample(zone_value(z), k == MAX_SAMPLES + 4);
        end
        steady = 1'b0;
    endtask

    task automatic random_setting();
        write_reg(CFG_TARGET, ($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 200000) - 100000);
        write_reg(CFG_TOLERANCE, ($urandom_range(0, 4) == 0) ? ($urandom >> 1)
                                                            : $urandom_range(1, 70000));
        write_reg(CFG_NULL, $urandom);
        write_reg(CFG_ORIGIN, ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1 << 20));
        write_reg(CFG_STEP, ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(1, 1 << 18));
    endtask

    task automatic random_trace(inout int sent);
        logic [VAL_W-1:0] vals[$];
        int segs;
        int n;
        zone_t z;
        if ($urandom_range(0, 7) == 0)
        begin
            // noise trace
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
            begin
                vals.push_back(zone_value(ZONE_ANY));
            end
        end
        else
        begin
            // outside, inside, outside, inside, outside runs
            segs = $urandom_range(1, 5);
            for (int seg = 0; seg < segs; seg++)
            begin
                n = (seg == 0 || seg == 4) ? $urandom_range(0, 3) : $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                begin
                    z = (seg % 2 == 1) ? ZONE_IN : ZONE_OUT;
                    case ($urandom_range(0, 19))
                        0: z = ZONE_EDGE;
                        1: z = ZONE_ANY;
                        default:
                        begin
                        end
                    endcase
                    vals.push_back(zone_value(z));
                end
            end
            if (vals.size() == 0)
            begin
                vals.push_back(zone_value(ZONE_IN));
            end
        end
        send_trace(vals);
        sent += vals.size();
    endtask

    task automatic test_random_traffic();
        int sent;
        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            random_setting();
            steady = (phase == 2);
            while (sent < (phase + 1) * 170)
            begin
                random_trace(sent);
                if ($urandom_range(0, 40) == 0)
                begin
                    wait_drained();
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        smp_valid = 1'b0;
        smp = '0;
        pick_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_target = longint'(TARGET_RESET);
        cfg_tol = longint'(TOLERANCE_RESET);
        cfg_null = longint'(NULL_RESET);
        cfg_origin = longint'(ORIGIN_RESET);
        cfg_step = longint'(STEP_RESET);
        clear_bounds();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_shapes();
        test_register_extremes();
        test_unmapped_index();
        test_overlong_trace();
        test_random_traffic();

        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tbbp_pkg.sv
hw/rtl/tbbp_depth.sv
hw/rtl/trace_body_boundary_picker.sv
hw/rtl/tbbp_checker.sv
tb/sv/tb_top.sv
